// ----- hdl/sbr_pkg.sv -----
// Package for small blob removal: shared constants and command codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbr_pkg;
  localparam int unsigned GridSideDefault = 128;
  localparam int unsigned CountMax = 32767;
  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeRun   = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;
  localparam logic CfgThreshold = 1'b0;
  localparam logic CfgSide      = 1'b1;
  localparam logic [14:0] ThresholdReset = 15'd16;
  localparam logic [7:0]  SideReset      = 8'd128;
endpackage
`default_nettype wire

// ----- hdl/small_blob_removal.sv -----
// Top level of small blob removal: sequencer, grid, visited map and queue.
// Depends on sbr_pkg, sbr_bitmem and sbr_qmem.
//
//  channel | signals                                          | direction
//  command | start busy mode_i col_i row_i land_in_i          | in
//  result  | done_o land_out_o removed_cells_o                | out
//  config  | cfg_valid cfg_ready cfg_index_i cfg_data_i       | in
//
// A write goes to the grid when the request is taken; a read passes through
// StRd1 and StRd2 and gives a registered result. A run first clears the
// visited map (one cell a cycle), then scans the used grid and for each
// region pops every queued cell and probes its 8 neighbors through the
// memories, each with one write and one read port; erasing a small
// region walks the queue again. The receiver cannot stall the result.
// Reset clears the controller; grid contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module small_blob_removal #(
  parameter int unsigned GRID_SIDE = sbr_pkg::GridSideDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode_i,
  input  wire logic [6:0]  col_i,
  input  wire logic [6:0]  row_i,
  input  wire logic        land_in_i,
  output logic             done_o,
  output logic             land_out_o,
  output logic [14:0]      removed_cells_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index_i,
  input  wire logic [14:0] cfg_data_i
);
  localparam int unsigned CW = $clog2(GRID_SIDE);   // coordinate bits
  localparam int unsigned AW = 2 * CW;              // cell address bits
  localparam int unsigned QW = AW + 1;              // queue counter bits
  localparam int unsigned SW = CW + 1;              // side bits

  localparam logic [3:0] StIdle = 4'd0, StRd1 = 4'd1, StRd2 = 4'd2,
    StClr = 4'd3, StScan = 4'd4, StScanW = 4'd5, StScanChk = 4'd6,
    StPop = 4'd7, StPopW = 4'd8, StNb = 4'd9, StNbW = 4'd10,
    StNbChk = 4'd11, StDecide = 4'd12, StErase = 4'd13, StEraseW = 4'd14,
    StDone = 4'd15;

  logic [3:0] st_q, st_d;
  logic [14:0] thr_q;
  logic [7:0] side_q;
  logic [SW-1:0] side;
  logic [CW-1:0] sr_q, sr_d, sc_q, sc_d;      // scan position
  logic [CW-1:0] cr_q, cr_d, cc_q, cc_d;      // popped cell
  logic [3:0] nb_q, nb_d;                      // neighbor index
  logic [QW-1:0] head_q, head_d, tail_q, tail_d;
  logic edge_q, edge_d;
  logic [14:0] tot_q, tot_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] naddr_q, naddr_d;
  logic [14:0] res_q, res_d;
  logic out_land_q, out_land_d, done_q, done_d;
  logic read_ok_q, read_ok_d;

  // memory ports
  logic g_we, g_wd, g_rd, v_we, v_wd, v_rd, q_we;
  logic [AW-1:0] g_wa, g_ra, v_wa, v_ra, q_wa, q_wd, q_ra, q_rd;

  // request coordinates fitted to the storage
  logic [CW-1:0] row_c, col_c;
  assign row_c = CW'(row_i);
  assign col_c = CW'(col_i);

  assign side = (side_q > GRID_SIDE) ? SW'(GRID_SIDE) : SW'(side_q);

  sbr_bitmem #(.AW(AW)) u_grid (.clk_i, .we_i(g_we), .waddr_i(g_wa),
    .wdata_i(g_wd), .raddr_i(g_ra), .rdata_o(g_rd));
  sbr_bitmem #(.AW(AW)) u_vis (.clk_i, .we_i(v_we), .waddr_i(v_wa),
    .wdata_i(v_wd), .raddr_i(v_ra), .rdata_o(v_rd));
  sbr_qmem #(.AW(AW)) u_queue (.clk_i, .we_i(q_we), .waddr_i(q_wa),
    .wdata_i(q_wd), .raddr_i(q_ra), .rdata_o(q_rd));

  // neighbor offsets
  logic signed [CW+1:0] nr, nc;
  logic [1:0] dr, dc;
  logic nb_in;
  always_comb begin
    case (nb_q)
      4'd0: begin dr = 2'd0; dc = 2'd0; end
      4'd1: begin dr = 2'd0; dc = 2'd1; end
      4'd2: begin dr = 2'd0; dc = 2'd2; end
      4'd3: begin dr = 2'd1; dc = 2'd0; end
      4'd4: begin dr = 2'd1; dc = 2'd2; end
      4'd5: begin dr = 2'd2; dc = 2'd0; end
      4'd6: begin dr = 2'd2; dc = 2'd1; end
      4'd7: begin dr = 2'd2; dc = 2'd2; end
      default: begin dr = 2'd1; dc = 2'd1; end
    endcase
    nr = $signed({2'b00, cr_q}) + $signed({{CW{1'b0}}, dr}) - $signed((CW+2)'(1));
    nc = $signed({2'b00, cc_q}) + $signed({{CW{1'b0}}, dc}) - $signed((CW+2)'(1));
    nb_in = (nr >= 0) && (nc >= 0) && (nr < $signed({1'b0, side}))
            && (nc < $signed({1'b0, side}));
  end

  assign busy = (st_q != StIdle);
  assign cfg_ready = (st_q == StIdle);
  assign done_o = done_q;
  assign land_out_o = out_land_q;
  assign removed_cells_o = res_q;

  always_comb begin
    st_d = st_q; sr_d = sr_q; sc_d = sc_q; cr_d = cr_q; cc_d = cc_q;
    nb_d = nb_q; head_d = head_q; tail_d = tail_q; edge_d = edge_q;
    tot_d = tot_q; clr_d = clr_q; naddr_d = naddr_q; res_d = 15'd0;
    out_land_d = 1'b0; done_d = 1'b0; read_ok_d = read_ok_q;
    g_we = 1'b0; g_wd = 1'b0; g_wa = {row_c, col_c};
    g_ra = {row_c, col_c};
    v_we = 1'b0; v_wd = 1'b0; v_wa = clr_q; v_ra = {sr_q, sc_q};
    q_we = 1'b0; q_wa = tail_q[AW-1:0]; q_wd = naddr_q; q_ra = head_q[AW-1:0];
    case (st_q)
      StIdle: if (start) begin
        case (mode_i)
          sbr_pkg::ModeWrite: begin
            // drop writes outside storage
            g_we = (32'(col_i) < GRID_SIDE) && (32'(row_i) < GRID_SIDE);
            g_wd = land_in_i;
          end
          sbr_pkg::ModeRead: begin
            read_ok_d = (32'(col_i) < GRID_SIDE) && (32'(row_i) < GRID_SIDE);
            naddr_d = {row_c, col_c};   // hold the address for the read
            st_d = StRd1;
          end
          sbr_pkg::ModeRun: begin
            clr_d = '0; tot_d = '0; st_d = StClr;
          end
          default: ;
        endcase
      end
      StRd1: begin   // grid read in flight
        g_ra = naddr_q; st_d = StRd2;
      end
      StRd2: begin
        out_land_d = read_ok_q & g_rd; done_d = 1'b1; st_d = StIdle;
      end
      StClr: begin
        v_we = 1'b1; v_wa = clr_q; v_wd = 1'b0; clr_d = clr_q + 1'b1;
        if (clr_q == {AW{1'b1}}) begin
          sr_d = '0; sc_d = '0;
          st_d = (side == '0) ? StDone : StScan;
        end
      end
      StScan: begin
        g_ra = {sr_q, sc_q}; v_ra = {sr_q, sc_q}; st_d = StScanW;
      end
      StScanW: begin
        g_ra = {sr_q, sc_q}; v_ra = {sr_q, sc_q}; st_d = StScanChk;
      end
      StScanChk: begin
        if (!v_rd && g_rd) begin
          // seed a new region
          v_we = 1'b1; v_wa = {sr_q, sc_q}; v_wd = 1'b1;
          q_we = 1'b1; q_wa = '0; q_wd = {sr_q, sc_q};
          head_d = '0; tail_d = QW'(1); edge_d = 1'b0; st_d = StPop;
        end else begin
          if (!v_rd) begin v_we = 1'b1; v_wa = {sr_q, sc_q}; v_wd = 1'b1; end
          st_d = StDecide; tail_d = '0; edge_d = 1'b1;  // advance only
        end
      end
      StPop: begin
        if (head_q == tail_q) begin
          st_d = StDecide;
        end else begin
          q_ra = head_q[AW-1:0]; st_d = StPopW;
        end
      end
      StPopW: begin
        head_d = head_q + 1'b1; st_d = StNb; nb_d = '0;
        cr_d = q_rd[AW-1:CW]; cc_d = q_rd[CW-1:0];
        if (q_rd[AW-1:CW] == '0 || q_rd[CW-1:0] == '0 ||
            SW'(q_rd[AW-1:CW]) == side - 1'b1 || SW'(q_rd[CW-1:0]) == side - 1'b1)
          edge_d = 1'b1;
      end
      StNb: begin
        if (nb_q == 4'd8) st_d = StPop;
        else if (!nb_in) nb_d = nb_q + 1'b1;
        else begin
          naddr_d = {nr[CW-1:0], nc[CW-1:0]};
          g_ra = {nr[CW-1:0], nc[CW-1:0]}; v_ra = {nr[CW-1:0], nc[CW-1:0]};
          st_d = StNbW;
        end
      end
      StNbW: begin
        g_ra = naddr_q; v_ra = naddr_q; st_d = StNbChk;
      end
      StNbChk: begin
        if (!v_rd && g_rd) begin
          v_we = 1'b1; v_wa = naddr_q; v_wd = 1'b1;
          q_we = 1'b1; q_wa = tail_q[AW-1:0]; q_wd = naddr_q;
          tail_d = tail_q + 1'b1;
        end
        nb_d = nb_q + 1'b1; st_d = StNb;
      end
      StDecide: begin
        if (!edge_q && (32'(tail_q) <= 32'(thr_q))) begin
          head_d = '0; st_d = StErase;
          if (32'(tot_q) + 32'(tail_q) > sbr_pkg::CountMax) tot_d = 15'h7FFF;
          else tot_d = tot_q + 15'(tail_q);
        end else begin
          // advance scan
          if (SW'(sc_q) == side - 1'b1) begin
            sc_d = '0;
            if (SW'(sr_q) == side - 1'b1) st_d = StDone;
            else begin sr_d = sr_q + 1'b1; st_d = StScan; end
          end else begin
            sc_d = sc_q + 1'b1; st_d = StScan;
          end
        end
      end
      StErase: begin
        if (head_q == tail_q) begin
          edge_d = 1'b1; st_d = StDecide;   // region gone, move on
        end else begin
          q_ra = head_q[AW-1:0]; st_d = StEraseW;
        end
      end
      StEraseW: begin
        g_we = 1'b1; g_wa = q_rd; g_wd = 1'b0;
        head_d = head_q + 1'b1; st_d = StErase;
      end
      StDone: begin
        res_d = tot_q; done_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; thr_q <= sbr_pkg::ThresholdReset;
      side_q <= sbr_pkg::SideReset; done_q <= 1'b0; res_q <= '0;
      out_land_q <= 1'b0; head_q <= '0; tail_q <= '0; edge_q <= 1'b0;
      tot_q <= '0; clr_q <= '0; read_ok_q <= 1'b0; nb_q <= '0;
    end else begin
      st_q <= st_d; done_q <= done_d; res_q <= res_d; out_land_q <= out_land_d;
      head_q <= head_d; tail_q <= tail_d; edge_q <= edge_d; tot_q <= tot_d;
      clr_q <= clr_d; read_ok_q <= read_ok_d; nb_q <= nb_d;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_i == sbr_pkg::CfgThreshold) thr_q <= cfg_data_i;
        else side_q <= cfg_data_i[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d; sc_q <= sc_d; cr_q <= cr_d; cc_q <= cc_d; naddr_q <= naddr_d;
  end
endmodule
`default_nettype wire

// ----- hdl/sbr_bitmem.sv -----
// One-bit-wide memory with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sbr_bitmem #(
  parameter int unsigned AW = 14
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic          wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic               rdata_o
);
  logic mem_q [2**AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/sbr_qmem.sv -----
// Region queue memory: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sbr_qmem #(
  parameter int unsigned AW = 14
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [AW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [AW-1:0]      rdata_o
);
  logic [AW-1:0] mem_q [2**AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- tb/sv/small_blob_checker.sv -----
// Checker for small blob removal: watches the command, result and config
// channels, predicts each result from its own grid copy and compares.
// Depends on sbr_pkg.
`timescale 1ns / 1ps
module small_blob_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  mode_i,
  input  logic [6:0]  col_i,
  input  logic [6:0]  row_i,
  input  logic        land_in_i,
  input  logic        done_i,
  input  logic        land_out_i,
  input  logic [14:0] removed_cells_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [14:0] cfg_data_i,
  output int          err_count_o,
  output int          pending_o
);
  localparam int Side = sbr_pkg::GridSideDefault;
  localparam int Cells = Side * Side;

  typedef struct packed {
    logic        land;
    logic [14:0] removed;
  } blob_result_t;

  blob_result_t result_fifo[$];
  logic [14:0]  threshold_q;
  logic [7:0]   side_q;
  bit           grid_q[Cells];
  bit           seen_q[Cells];
  int           bfs_q[Cells];

  // Erase every enclosed region of at most threshold_q cells; return count.
  function automatic logic [14:0] sweep_blobs();
    int span, head, tail, total, idx, r, c, nr, nc, n;
    bit on_edge;
    span  = (side_q > Side) ? Side : side_q;
    total = 0;
    for (int k = 0; k < Cells; k++) seen_q[k] = 0;
    for (int s = 0; s < span * span; s++) begin
      idx = (s / span) * Side + (s % span);
      if (seen_q[idx]) continue;
      seen_q[idx] = 1;
      if (!grid_q[idx]) continue;
      head = 0;
      tail = 1;
      bfs_q[0] = idx;
      on_edge = 0;
      while (head < tail) begin
        r = bfs_q[head] / Side;
        c = bfs_q[head] % Side;
        head++;
        if (r == 0 || c == 0 || r == span - 1 || c == span - 1) on_edge = 1;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = r + dr;
            nc = c + dc;
            if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= span || nc >= span)
              continue;
            n = nr * Side + nc;
            if (!seen_q[n] && grid_q[n]) begin
              seen_q[n] = 1;
              bfs_q[tail++] = n;
            end
          end
        end
      end
      if (on_edge || tail > threshold_q) continue;
      for (int k = 0; k < tail; k++) grid_q[bfs_q[k]] = 0;
      total += tail;
      if (total > sbr_pkg::CountMax) total = sbr_pkg::CountMax;
    end
    return total[14:0];
  endfunction

  assign pending_o = result_fifo.size();

  always @(posedge clk_i or negedge rst_ni) begin
    blob_result_t want;
    if (!rst_ni) begin
      threshold_q = sbr_pkg::ThresholdReset;
      side_q      = sbr_pkg::SideReset;
      result_fifo.delete();
      err_count_o = 0;
    end else begin
      // Retire the oldest expectation first: it predates any same-edge request.
      if (done_i) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: result with nothing expected: land %0b removed %0d",
                   $time, land_out_i, removed_cells_i);
          err_count_o++;
        end else begin
          want = result_fifo.pop_front();
          if (want.land !== land_out_i) begin
            $display("%0t: land_out expected %0b actual %0b",
                     $time, want.land, land_out_i);
            err_count_o++;
          end
          if (want.removed !== removed_cells_i) begin
            $display("%0t: removed_cells expected %0d actual %0d",
                     $time, want.removed, removed_cells_i);
            err_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == sbr_pkg::CfgThreshold) threshold_q = cfg_data_i;
        else side_q = cfg_data_i[7:0];
      end
      if (start_i && !busy_i) begin
        case (mode_i)
          sbr_pkg::ModeWrite: grid_q[row_i * Side + col_i] = land_in_i;
          sbr_pkg::ModeRun: begin
            want.land    = 1'b0;
            want.removed = sweep_blobs();
            result_fifo  = {result_fifo, want};
          end
          sbr_pkg::ModeRead: begin
            want.land    = grid_q[row_i * Side + col_i];
            want.removed = '0;
            result_fifo  = {result_fifo, want};
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- tb/sv/small_blob_removal_tb.sv -----
// Testbench top for small blob removal: clock, reset, command and config
// stimulus, watchdog and verdict. Depends on sbr_pkg, small_blob_checker
// and the small_blob_removal RTL.
`timescale 1ns / 1ps
module small_blob_removal_tb;
  // Mode code with no function: the block must swallow it silently.
  localparam logic [1:0] ModeIdle = 2'd3;
  // No request of any kind for this many cycles means the block hung.
  localparam int StallLimit = 200_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode_i = sbr_pkg::ModeWrite;
  logic [6:0]  col_i = '0;
  logic [6:0]  row_i = '0;
  logic        land_in_i = 1'b0;
  logic        done_o;
  logic        land_out_o;
  logic [14:0] removed_cells_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index_i = sbr_pkg::CfgThreshold;
  logic [14:0] cfg_data_i = '0;
  int          err_count;
  int          pending;
  int          idle_pct;
  int          quiet_cycles = 0;
  int          cur_side;
  // Cells written outside the used square, kept so reads can revisit them.
  logic [13:0] stray_cells[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  small_blob_removal DUT (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .col_i, .row_i, .land_in_i,
    .done_o, .land_out_o, .removed_cells_o,
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  small_blob_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .mode_i, .col_i, .row_i,
    .land_in_i, .done_i(done_o), .land_out_i(land_out_o),
    .removed_cells_i(removed_cells_o), .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .err_count_o(err_count), .pending_o(pending)
  );

  // Watchdog: count cycles in which no request of any kind went through.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Issue one command request; hold start until the block takes it, then, with a
  // chance set by the current idle setting, drop start for a random gap.
  task automatic send_cmd(input logic [1:0] m, input int r, input int c, input bit v);
    int gap;
    start     <= 1'b1;
    mode_i    <= m;
    row_i     <= r[6:0];
    col_i     <= c[6:0];
    land_in_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int val);
    drain();
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[14:0];
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Fill the used square with land at roughly density_pct percent.
  task automatic fill_square(input int span, input int density_pct);
    for (int r = 0; r < span; r++)
      for (int c = 0; c < span; c++)
        send_cmd(sbr_pkg::ModeWrite, r, c, $urandom_range(99) < density_pct);
  endtask

  task automatic random_item();
    int pick, r, c;
    logic [13:0] spot;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // Write, sometimes anywhere; cells off the used square are stored, not swept.
      if ($urandom_range(3) == 0) begin
        r = $urandom_range(127);
        c = $urandom_range(127);
        if (r >= cur_side || c >= cur_side) stray_cells = {stray_cells, {r[6:0], c[6:0]}};
      end else begin
        r = $urandom_range(cur_side - 1);
        c = $urandom_range(cur_side - 1);
      end
      send_cmd(sbr_pkg::ModeWrite, r, c, $urandom_range(99) < 60);
    end else if (pick < 82) begin
      if (stray_cells.size() > 0 && $urandom_range(4) == 0) begin
        spot = stray_cells[$urandom_range(stray_cells.size() - 1)];
        send_cmd(sbr_pkg::ModeRead, spot[13:7], spot[6:0], $urandom_range(1));
      end else begin
        send_cmd(sbr_pkg::ModeRead, $urandom_range(cur_side - 1),
                 $urandom_range(cur_side - 1), $urandom_range(1));
      end
    end else if (pick < 97) begin
      send_cmd(sbr_pkg::ModeRun, $urandom_range(127), $urandom_range(127),
               $urandom_range(1));
    end else begin
      send_cmd(ModeIdle, $urandom_range(127), $urandom_range(127), $urandom_range(1));
    end
  endtask

  initial begin
    int thr;
    idle_pct     = 0;
    cur_side     = 4;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a diagonal pair inside a 4x4 square is one region under
    // 8-connectivity and, being enclosed and small, gets erased.
    write_reg(sbr_pkg::CfgSide, 4);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send_cmd(sbr_pkg::ModeWrite, r, c, (r == c) && (r == 1 || r == 2));
    send_cmd(sbr_pkg::ModeWrite, 127, 127, 1'b1);   // stored beyond the used square
    send_cmd(ModeIdle, 127, 127, 1'b1);              // unused mode: no result
    send_cmd(sbr_pkg::ModeRun, 0, 0, 1'b0);
    send_cmd(sbr_pkg::ModeRead, 1, 1, 1'b0);
    send_cmd(sbr_pkg::ModeRead, 127, 127, 1'b0);
    send_cmd(sbr_pkg::ModeWrite, 1, 2, 1'b1);
    write_reg(sbr_pkg::CfgThreshold, 0);             // nothing is small enough now
    send_cmd(sbr_pkg::ModeRun, 0, 0, 1'b0);
    send_cmd(sbr_pkg::ModeRead, 1, 2, 1'b0);
    write_reg(sbr_pkg::CfgSide, 0);                  // empty grid removes nothing
    send_cmd(sbr_pkg::ModeRun, 0, 0, 1'b0);
    write_reg(sbr_pkg::CfgSide, 1);                  // a single cell sits on the edge
    send_cmd(sbr_pkg::ModeRun, 0, 0, 1'b0);
    write_reg(sbr_pkg::CfgSide, 2);
    send_cmd(sbr_pkg::ModeRun, 0, 0, 1'b0);

    // Random phases: fresh square, fresh settings, then a mix of requests.
    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 75 : 7);
      cur_side = (ph == 8) ? 10 : $urandom_range(3, 9);
      case (ph % 4)
        0: thr = $urandom_range(0, 6);
        1: thr = $urandom_range(1, 30);
        2: thr = 16384;
        default: thr = 32767;
      endcase
      write_reg(sbr_pkg::CfgThreshold, thr);
      write_reg(sbr_pkg::CfgSide, cur_side);
      fill_square(cur_side, $urandom_range(25, 60));
      repeat (20) random_item();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
